@@ hw/rtl/cht_pkg.sv @@
package cht_pkg;

    localparam int NUM_BUCKETS = 256;
    localparam int NUM_NODES   = 256;
    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int NODE_W = $clog2(NUM_NODES);
    localparam int LINK_W = NODE_W + 1;
    localparam int CNT_W  = NODE_W + 1;
    localparam int STEP_W = NODE_W + 1;
    localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
    localparam int HASH_SHIFT = 16;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_NODES);

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_HAS    = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] key_in;
        logic [31:0] value_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value_out;
        logic        map_empty;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_HWAIT, S_HEAD, S_RD, S_CHK, S_LINK,
        S_UNLINK, S_DONE, S_OUT
    } state_t;

    // Hash unit control and status.
    typedef struct packed {
        logic        start;
        logic [31:0] key;
    } hash_req_t;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] bucket;
    } hash_rsp_t;

endpackage

@@ hw/rtl/cht_hash.sv @@
module cht_hash (
    input  logic              aclk,
    input  logic              aresetn,
    input  cht_pkg::hash_req_t req,
    output cht_pkg::hash_rsp_t rsp
);
    // One xor-shift and one registered multiply per round, shared over two rounds.
    logic [31:0] x_reg, x_next;
    logic [2:0]  ph_reg, ph_next;
    logic [31:0] mixed;

    assign mixed = (x_reg >> cht_pkg::HASH_SHIFT) ^ x_reg;

    always_comb begin
        x_next  = x_reg;
        ph_next = ph_reg;
        if (req.start) begin
            x_next  = req.key;
            ph_next = 3'd1;
        end else if (ph_reg == 3'd1 || ph_reg == 3'd2) begin
            x_next  = mixed * cht_pkg::HASH_MUL;
            ph_next = ph_reg + 3'd1;
        end else if (ph_reg == 3'd3) begin
            x_next  = mixed;
            ph_next = 3'd4;
        end else begin
            ph_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= 3'd0;
        end else begin
            ph_reg <= ph_next;
        end
        x_reg <= x_next;
    end

    assign rsp.done   = (ph_reg == 3'd4);
    assign rsp.bucket = x_reg[cht_pkg::BKT_W-1:0];
endmodule

@@ hw/rtl/chained_hash_table.sv @@
// Channel | Ports       | Payload
// input   | s_valid/s_ready | s_data (in_word_t: opcode, key_in, value_in)
// result  | m_valid/m_ready | m_data (out_word_t: status, found, value_out, map_empty)
// One word is handled at a time. Hashing, a head read and the head decision come
// first, and a done state settles the result before the result word is offered.
// Each chain node visited adds a read and a check through the single node memory
// read port; a set adds a state to write its node, a remove one to unlink.
// A set walks to the tail; others stop at the first matching key.
// Reset clears the bucket valid bits and counters.
// A stalled result holds the block; s_ready is low until the result is taken.
module chained_hash_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cht_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cht_pkg::out_word_t m_data
);
    localparam int NW = cht_pkg::NODE_W;
    localparam int LW = cht_pkg::LINK_W;
    localparam int CW = cht_pkg::CNT_W;
    localparam int BW = cht_pkg::BKT_W;

    logic [LW-1:0] head_mem [cht_pkg::NUM_BUCKETS];
    logic [cht_pkg::NUM_BUCKETS-1:0] head_vld_reg;
    logic [31:0]   key_mem  [cht_pkg::NUM_NODES];
    logic [31:0]   val_mem  [cht_pkg::NUM_NODES];
    logic [LW-1:0] link_mem [cht_pkg::NUM_NODES];
    logic [NW-1:0] stk_mem  [cht_pkg::NUM_NODES];

    cht_pkg::state_t state_reg, state_next;
    cht_pkg::in_word_t in_reg;
    cht_pkg::out_word_t out_reg, out_next;
    cht_pkg::hash_req_t hreq;
    cht_pkg::hash_rsp_t hrsp;

    logic [BW-1:0] bkt_reg, bkt_next;
    logic [LW-1:0] cur_reg, cur_next, prv_reg, prv_next, new_reg, new_next;
    logic [CW-1:0] fresh_reg, fresh_next, rec_reg, rec_next, live_reg, live_next;
    logic [cht_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [LW-1:0] head_q;
    logic          head_vq;
    logic [31:0]   key_q, val_q;
    logic [LW-1:0] link_q;
    logic [NW-1:0] stk_q;

    // Write strobes.
    logic head_we, link_we, node_we, val_we, stk_we;
    logic [LW-1:0] head_wd, link_wd;
    logic [NW-1:0] link_wa, stk_wd;
    logic [NW-1:0] rd_addr;

    cht_hash u_hash (.aclk(aclk), .aresetn(aresetn), .req(hreq), .rsp(hrsp));

    assign s_ready = (state_reg == cht_pkg::S_IDLE);
    assign m_valid = (state_reg == cht_pkg::S_OUT);
    assign m_data  = out_reg;
    assign hreq.start = s_valid && s_ready;
    assign hreq.key   = s_data.key_in;
    assign rd_addr = cur_reg[NW-1:0];

    always_comb begin
        state_next = state_reg;
        out_next = out_reg;
        bkt_next = bkt_reg;
        cur_next = cur_reg;
        prv_next = prv_reg;
        new_next = new_reg;
        fresh_next = fresh_reg;
        rec_next = rec_reg;
        live_next = live_reg;
        steps_next = steps_reg;
        head_we = 1'b0; head_wd = cht_pkg::NULL_LINK;
        link_we = 1'b0; link_wd = cht_pkg::NULL_LINK; link_wa = '0;
        node_we = 1'b0; val_we = 1'b0;
        stk_we = 1'b0; stk_wd = rd_addr;
        case (state_reg)
            cht_pkg::S_IDLE: begin
                if (s_valid) begin
                    out_next = '0;
                    state_next = cht_pkg::S_HASH;
                end
            end
            cht_pkg::S_HASH: begin
                if (hrsp.done) begin
                    bkt_next = hrsp.bucket;
                    state_next = cht_pkg::S_HWAIT;
                end
            end
            cht_pkg::S_HWAIT: begin
                // Pop of the recycle stack is read here as well.
                state_next = cht_pkg::S_HEAD;
            end
            cht_pkg::S_HEAD: begin
                cur_next = head_vq ? head_q : cht_pkg::NULL_LINK;
                prv_next = cht_pkg::NULL_LINK;
                steps_next = '0;
                state_next = cht_pkg::S_DONE;
                if (in_reg.opcode == cht_pkg::OP_SET) begin
                    if (rec_reg != '0) begin
                        new_next = {1'b0, stk_q};
                        rec_next = rec_reg - CW'(1);
                    end else if (fresh_reg < CW'(cht_pkg::NUM_NODES)) begin
                        new_next = fresh_reg;
                        fresh_next = fresh_reg + CW'(1);
                    end else begin
                        new_next = cht_pkg::NULL_LINK;
                    end
                    if (rec_reg == '0 && fresh_reg >= CW'(cht_pkg::NUM_NODES)) begin
                        out_next.status = cht_pkg::ST_FULL;
                        state_next = cht_pkg::S_DONE;
                    end else begin
                        state_next = cht_pkg::S_LINK;
                    end
                end else if (in_reg.opcode <= cht_pkg::OP_UPDATE) begin
                    state_next = cht_pkg::S_RD;
                end
            end
            cht_pkg::S_LINK: begin
                // Write the new node; make it the head of an empty bucket, else walk to the tail.
                node_we = 1'b1;
                live_next = live_reg + CW'(1);
                if (cur_reg[NW]) begin
                    head_we = 1'b1;
                    head_wd = new_reg;
                    state_next = cht_pkg::S_DONE;
                end else begin
                    state_next = cht_pkg::S_RD;
                end
            end
            cht_pkg::S_RD: begin
                state_next = cht_pkg::S_CHK;
            end
            cht_pkg::S_CHK: begin
                if (in_reg.opcode == cht_pkg::OP_SET) begin
                    if (!link_q[NW] && steps_reg < cht_pkg::STEP_W'(cht_pkg::NUM_NODES)) begin
                        cur_next = link_q;
                        steps_next = steps_reg + 1'b1;
                        state_next = cht_pkg::S_RD;
                    end else begin
                        link_we = 1'b1; link_wa = rd_addr; link_wd = new_reg;
                        state_next = cht_pkg::S_DONE;
                    end
                end else if (key_q == in_reg.key_in) begin
                    out_next.found = 1'b1;
                    state_next = cht_pkg::S_DONE;
                    if (in_reg.opcode == cht_pkg::OP_GET) begin
                        out_next.value_out = val_q;
                    end else if (in_reg.opcode == cht_pkg::OP_UPDATE) begin
                        val_we = 1'b1;
                    end else if (in_reg.opcode == cht_pkg::OP_REMOVE) begin
                        state_next = cht_pkg::S_UNLINK;
                    end
                end else begin
                    prv_next = cur_reg;
                    cur_next = link_q;
                    steps_next = steps_reg + 1'b1;
                    if (link_q[NW] ||
                        steps_reg + 1'b1 >= cht_pkg::STEP_W'(cht_pkg::NUM_NODES)) begin
                        out_next.status = cht_pkg::ST_NOTFOUND;
                        state_next = cht_pkg::S_DONE;
                    end else begin
                        state_next = cht_pkg::S_RD;
                    end
                end
            end
            cht_pkg::S_UNLINK: begin
                if (prv_reg[NW]) begin
                    head_we = 1'b1; head_wd = link_q;
                end else begin
                    link_we = 1'b1; link_wa = prv_reg[NW-1:0]; link_wd = link_q;
                end
                if (rec_reg < CW'(cht_pkg::NUM_NODES)) begin
                    stk_we = 1'b1;
                    rec_next = rec_reg + CW'(1);
                end
                if (live_reg != '0) live_next = live_reg - CW'(1);
                state_next = cht_pkg::S_DONE;
            end
            cht_pkg::S_DONE: begin
                out_next.map_empty = (live_reg == '0);
                state_next = cht_pkg::S_OUT;
            end
            cht_pkg::S_OUT: begin
                if (m_ready) state_next = cht_pkg::S_IDLE;
            end
            default: state_next = cht_pkg::S_IDLE;
        endcase
        // An empty bucket, or a head beyond the pool, ends a lookup as not found.
        if (state_reg == cht_pkg::S_HEAD && cur_next[NW] && in_reg.opcode != cht_pkg::OP_SET
            && in_reg.opcode <= cht_pkg::OP_UPDATE) begin
            out_next.status = cht_pkg::ST_NOTFOUND;
            state_next = cht_pkg::S_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cht_pkg::S_IDLE;
            head_vld_reg <= '0;
            fresh_reg <= '0;
            rec_reg <= '0;
            live_reg <= '0;
        end else begin
            state_reg <= state_next;
            fresh_reg <= fresh_next;
            rec_reg <= rec_next;
            live_reg <= live_next;
            if (head_we) head_vld_reg[bkt_reg] <= 1'b1;
        end
        if (s_valid && s_ready) in_reg <= s_data;
        out_reg <= out_next;
        bkt_reg <= bkt_next;
        cur_reg <= cur_next;
        prv_reg <= prv_next;
        new_reg <= new_next;
        steps_reg <= steps_next;
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[bkt_reg] <= head_wd;
        head_q  <= head_mem[bkt_reg];
        head_vq <= head_vld_reg[bkt_reg];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            key_mem[new_reg[NW-1:0]] <= in_reg.key_in;
        end
        if (node_we || val_we) begin
            val_mem[node_we ? new_reg[NW-1:0] : rd_addr] <= in_reg.value_in;
        end
        if (node_we || link_we) begin
            link_mem[node_we ? new_reg[NW-1:0] : link_wa] <= node_we ? cht_pkg::NULL_LINK
                                                                     : link_wd;
        end
        key_q  <= key_mem[rd_addr];
        val_q  <= val_mem[rd_addr];
        link_q <= link_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) stk_mem[rec_reg[NW-1:0]] <= stk_wd;
        stk_q <= stk_mem[rec_reg[NW-1:0] - NW'(1)];
    end

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");
    a_live: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(cht_pkg::NUM_NODES)) else $error("live count overflow");
endmodule

@@ tb/cht_checker.sv @@
`timescale 1ns / 100ps

module cht_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cht_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  cht_pkg::out_word_t m_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    // Shadow copy of the map, kept at the block's widths.
    logic [cht_pkg::LINK_W-1:0] head_tbl [cht_pkg::NUM_BUCKETS];
    logic [31:0]                key_tbl  [cht_pkg::NUM_NODES];
    logic [31:0]                val_tbl  [cht_pkg::NUM_NODES];
    logic [cht_pkg::LINK_W-1:0] link_tbl [cht_pkg::NUM_NODES];
    logic [cht_pkg::NODE_W-1:0] free_stack [cht_pkg::NUM_NODES];
    int                         fresh_used, free_depth, live_entries;
    cht_pkg::out_word_t         expected_words [$];

    function automatic logic [cht_pkg::BKT_W-1:0] bucket_index(input logic [31:0] k);
        logic [31:0] x;
        x = k;
        x = ((x >> cht_pkg::HASH_SHIFT) ^ x) * cht_pkg::HASH_MUL;
        x = ((x >> cht_pkg::HASH_SHIFT) ^ x) * cht_pkg::HASH_MUL;
        x = (x >> cht_pkg::HASH_SHIFT) ^ x;
        return x[cht_pkg::BKT_W-1:0];
    endfunction

    task automatic clear_map();
        for (int i = 0; i < cht_pkg::NUM_BUCKETS; i++) head_tbl[i] = cht_pkg::NULL_LINK;
        fresh_used = 0;
        free_depth = 0;
        live_entries = 0;
        expected_words.delete();
    endtask

    function automatic cht_pkg::out_word_t apply_word(input cht_pkg::in_word_t w);
        cht_pkg::out_word_t r;
        logic [cht_pkg::BKT_W-1:0] b;
        int n, p, t, steps;
        r = '0;
        b = bucket_index(w.key_in);
        if (w.opcode == cht_pkg::OP_SET) begin
            if (free_depth > 0) begin
                free_depth--;
                n = int'(free_stack[free_depth]);
            end else if (fresh_used < cht_pkg::NUM_NODES) begin
                n = fresh_used++;
            end else begin
                n = cht_pkg::NUM_NODES;
            end
            if (n >= cht_pkg::NUM_NODES) begin
                r.status = cht_pkg::ST_FULL;
            end else begin
                key_tbl[n] = w.key_in;
                val_tbl[n] = w.value_in;
                link_tbl[n] = cht_pkg::NULL_LINK;
                t = int'(head_tbl[b]);
                if (t >= cht_pkg::NUM_NODES) begin
                    head_tbl[b] = cht_pkg::LINK_W'(n);
                end else begin
                    steps = 0;
                    while (int'(link_tbl[t]) < cht_pkg::NUM_NODES
                           && steps < cht_pkg::NUM_NODES) begin
                        t = int'(link_tbl[t]);
                        steps++;
                    end
                    link_tbl[t] = cht_pkg::LINK_W'(n);
                end
                live_entries++;
            end
        end else if (w.opcode <= cht_pkg::OP_UPDATE) begin
            p = cht_pkg::NUM_NODES;
            n = int'(head_tbl[b]);
            steps = 0;
            while (n < cht_pkg::NUM_NODES && steps < cht_pkg::NUM_NODES
                   && key_tbl[n] != w.key_in) begin
                p = n;
                n = int'(link_tbl[n]);
                steps++;
            end
            if (n >= cht_pkg::NUM_NODES || steps >= cht_pkg::NUM_NODES) begin
                r.status = cht_pkg::ST_NOTFOUND;
            end else begin
                r.found = 1'b1;
                case (w.opcode)
                    cht_pkg::OP_GET: r.value_out = val_tbl[n];
                    cht_pkg::OP_REMOVE: begin
                        if (p >= cht_pkg::NUM_NODES) head_tbl[b] = link_tbl[n];
                        else link_tbl[p] = link_tbl[n];
                        if (free_depth < cht_pkg::NUM_NODES)
                            free_stack[free_depth++] = cht_pkg::NODE_W'(n);
                        if (live_entries > 0) live_entries--;
                    end
                    cht_pkg::OP_UPDATE: val_tbl[n] = w.value_in;
                    default: ;
                endcase
            end
        end
        r.map_empty = (live_entries == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", result_count, msg);
        fail_count++;
    endtask

    assign pending_count = expected_words.size();

    always @(posedge aclk) begin
        cht_pkg::out_word_t e;
        if (!aresetn) begin
            clear_map();
            result_count <= 0;
        end else begin
            if (s_valid && s_ready) expected_words.push_back(apply_word(s_data));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    e = expected_words.pop_front();
                    if (m_data.status != e.status)
                        report_mismatch($sformatf("status got %h expected %h",
                                                  m_data.status, e.status));
                    if (m_data.found != e.found)
                        report_mismatch($sformatf("found got %h expected %h",
                                                  m_data.found, e.found));
                    if (m_data.value_out != e.value_out)
                        report_mismatch($sformatf("value_out got %h expected %h",
                                                  m_data.value_out, e.value_out));
                    if (m_data.map_empty != e.map_empty)
                        report_mismatch($sformatf("map_empty got %h expected %h",
                                                  m_data.map_empty, e.map_empty));
                end
                result_count <= result_count + 1;
            end
        end
    end
endmodule

@@ tb/chained_hash_table_test.sv @@
`timescale 1ns / 100ps

module chained_hash_table_test;
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    cht_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    cht_pkg::out_word_t m_data;
    int        fail_count, pending_count, result_count;
    int        sent_count;
    logic      hold_off;
    logic [31:0] key_pool [16];

    chained_hash_table dut (.*);

    cht_checker checker_i (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #20ms;
        $display("Timeout after %0d results", result_count);
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stall per word, and one long hold-off on request.
    initial begin
        int gap;
        bit held;
        m_ready = 1'b0;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off && !held) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                held = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [31:0] k,
                             input logic [31:0] v, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, key_in: k, value_in: v};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return key_pool[4'($urandom_range(0, 15))];
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        int waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        hold_off = 1'b0;
        sent_count = 0;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hffff_ffff;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-map misses, extremes, duplicates, unused opcodes.
        send_word(cht_pkg::OP_GET, 32'h0, 32'h0, 0);
        send_word(cht_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0, 0);
        send_word(cht_pkg::OP_UPDATE, 32'h1234, 32'hffff_ffff, 0);
        send_word(cht_pkg::OP_HAS, 32'h1234, 32'h0, 0);
        send_word(cht_pkg::OP_SET, 32'h0, 32'hffff_ffff, 0);
        send_word(cht_pkg::OP_SET, 32'hffff_ffff, 32'h0, 0);
        send_word(cht_pkg::OP_SET, 32'h0, 32'h5555_aaaa, 0);
        send_word(cht_pkg::OP_GET, 32'h0, 32'h0, 0);
        send_word(cht_pkg::OP_HAS, 32'hffff_ffff, 32'h0, 0);
        send_word(cht_pkg::OP_UPDATE, 32'h0, 32'haaaa_5555, 0);
        send_word(cht_pkg::OP_GET, 32'h0, 32'h0, 0);
        send_word(cht_pkg::OP_REMOVE, 32'h0, 32'h0, 0);
        send_word(cht_pkg::OP_GET, 32'h0, 32'h0, 0);
        send_word(3'd5, 32'h0, 32'h0, 0);
        send_word(3'd6, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_word(3'd7, 32'h0, 32'h0, 0);
        send_word(cht_pkg::OP_REMOVE, 32'h0, 32'h0, 0);
        send_word(cht_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0, 0);
        send_word(cht_pkg::OP_HAS, 32'h0, 32'h0, 0);

        // Fill the pool past capacity to reach the full status, then drain part of it.
        for (int i = 0; i < 262; i++)
            send_word(cht_pkg::OP_SET, i * 32'h0101_0101, $urandom(), 1);
        send_word(cht_pkg::OP_GET, 32'h0202_0202, 32'h0, 0);
        for (int i = 0; i < 100; i++)
            send_word(cht_pkg::OP_REMOVE, i * 32'h0101_0101, 32'h0, 1);

        // Back-pressure: the result side stops while words keep coming.
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++) send_word(cht_pkg::OP_SET, $urandom(), $urandom(), 1);

        for (int i = 0; i < 1400; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_word(op, pick_key(), $urandom(), $urandom_range(0, 4) == 0);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (50) @(posedge aclk);
        $display("Sent %0d words and checked %0d results, covering set, has, get, remove,",
                 sent_count, result_count);
        $display("update, unused opcodes, duplicate keys, a full pool and output back-pressure.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
